// ===== rtl/ndef_record_deframer_unit_defines.svh =====
// assertion macros for the ndef record deframer
// used by the top level only; no other dependencies
`ifndef NDEF_RECORD_DEFRAMER_UNIT_DEFINES_SVH
`define NDEF_RECORD_DEFRAMER_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define NDR_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("ndr assertion failed");
`define NDR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("ndr assertion failed");
`else
`define NDR_ASSERT_NOW(label, clk, rst, ante, cons)
`define NDR_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/ndr_pkg.sv =====
// shared types, constants and the tnf check for the ndef record deframer
// no dependencies
package ndr_pkg;

   localparam int unsigned LONG_LENGTH_BYTES = 4;
   localparam logic [31:0] MAX_PAYLOAD_RESET = 32'd1048576;

   localparam logic [1:0] KIND_TYPE    = 2'd0;
   localparam logic [1:0] KIND_ID      = 2'd1;
   localparam logic [1:0] KIND_PAYLOAD = 2'd2;
   localparam logic [1:0] KIND_NONE    = 2'd3;

   localparam logic [3:0] ERR_NONE          = 4'd0;
   localparam logic [3:0] ERR_NO_MB         = 4'd1;
   localparam logic [3:0] ERR_LATE_MB       = 4'd2;
   localparam logic [3:0] ERR_IL_IN_CHUNK   = 4'd3;
   localparam logic [3:0] ERR_CF_WITH_ME    = 4'd4;
   localparam logic [3:0] ERR_CHUNK_TNF     = 4'd5;
   localparam logic [3:0] ERR_UNCHANGED_TNF = 4'd6;
   localparam logic [3:0] ERR_CHUNK_TYPE    = 4'd7;
   localparam logic [3:0] ERR_NO_TYPE       = 4'd8;
   localparam logic [3:0] ERR_PAYLOAD_LONG  = 4'd9;
   localparam logic [3:0] ERR_MERGED_LONG   = 4'd10;
   localparam logic [3:0] ERR_TRUNCATED     = 4'd11;

   localparam logic [0:0] CSR_SINGLE_MODE = 1'd0;
   localparam logic [0:0] CSR_MAX_PAYLOAD = 1'd1;

   localparam logic [2:0] TNF_VOID       = 3'd0;
   localparam logic [2:0] TNF_WELLKNOWN  = 3'd1;
   localparam logic [2:0] TNF_MIME       = 3'd2;
   localparam logic [2:0] TNF_ABS_URI    = 3'd3;
   localparam logic [2:0] TNF_EXTERNAL   = 3'd4;
   localparam logic [2:0] TNF_OPAQUE     = 3'd5;
   localparam logic [2:0] TNF_CONT_CHUNK = 3'd6;
   localparam logic [2:0] TNF_RSVD       = 3'd7;

   // present flags: bit 0 type, bit 1 id, bit 2 payload
   localparam int unsigned PF_TYPE    = 0;
   localparam int unsigned PF_ID      = 1;
   localparam int unsigned PF_PAYLOAD = 2;

   typedef struct packed {
      logic        single_mode;
      logic [31:0] max_payload;
   } ndr_cfg_type;

   typedef struct packed {
      logic       have;
      logic [1:0] kind;
      logic [7:0] data;
      logic [2:0] tnf;
      logic       done;
      logic       ok;
      logic       msg;
      logic [3:0] err;
   } ndr_result_type;

   function automatic logic tnf_pass(input logic [2:0] tnf, input logic [2:0] flags);
      logic pass;
      case (tnf)
         TNF_VOID: pass = (flags == 3'b000);
         TNF_WELLKNOWN, TNF_MIME, TNF_ABS_URI, TNF_EXTERNAL: pass = 1'b1;
         TNF_OPAQUE, TNF_RSVD: pass = !flags[PF_TYPE];
         default: pass = 1'b0;
      endcase
      return pass;
   endfunction

endpackage

// ===== rtl/ndr_csr.sv =====
// configuration registers of the ndef record deframer
// depends on ndr_pkg
module ndr_csr
   import ndr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [31:0] csr_wdata,
   output ndr_cfg_type cfg
);

   logic        single_ff, single_in;
   logic [31:0] max_ff, max_in;

   always_comb begin
      single_in = single_ff;
      max_in    = max_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_SINGLE_MODE: single_in = csr_wdata[0];
            CSR_MAX_PAYLOAD: max_in    = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         single_ff <= 1'b0;
         max_ff    <= MAX_PAYLOAD_RESET;
      end else begin
         single_ff <= single_in;
         max_ff    <= max_in;
      end
   end

   assign cfg.single_mode = single_ff;
   assign cfg.max_payload = max_ff;

endmodule

// ===== rtl/ndr_parser.sv =====
// record header decoder and field sequencer: state registers and next-state logic
// depends on ndr_pkg
module ndr_parser
   import ndr_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           step,
   input  logic [7:0]     in_byte,
   input  logic           frame_last,
   input  ndr_cfg_type    cfg,
   output ndr_result_type res
);

   localparam logic [3:0] PH_HEAD    = 4'd0;
   localparam logic [3:0] PH_TYPELEN = 4'd1;
   localparam logic [3:0] PH_PAYLEN  = 4'd2;
   localparam logic [3:0] PH_IDLEN   = 4'd3;
   localparam logic [3:0] PH_TYPE    = 4'd4;
   localparam logic [3:0] PH_ID      = 4'd5;
   localparam logic [3:0] PH_PAYLOAD = 4'd6;
   localparam logic [3:0] PH_SKIP    = 4'd7;
   localparam logic [3:0] PH_DONE    = 4'd8;

   // header bits: 3 me, 2 cf, 1 sr, 0 il
   localparam int unsigned HB_IL = 0;
   localparam int unsigned HB_SR = 1;
   localparam int unsigned HB_CF = 2;
   localparam int unsigned HB_ME = 3;

   localparam logic [1:0] LEN_BYTES_AFTER_FIRST = 2'(LONG_LENGTH_BYTES - 1);

   logic [3:0]  phase_ff, phase_in;
   logic [3:0]  hdr_ff, hdr_in;
   logic [2:0]  tnf_ff, tnf_in;
   logic [7:0]  type_cnt_ff, type_cnt_in;
   logic [7:0]  id_cnt_ff, id_cnt_in;
   logic [31:0] pay_cnt_ff, pay_cnt_in;
   logic [1:0]  len_left_ff, len_left_in;
   logic        in_chunk_ff, in_chunk_in;
   logic        seen_ff, seen_in;
   logic [31:0] merged_ff, merged_in;
   logic [2:0]  present_ff, present_in;

   logic        do_lk, do_next, do_end;
   logic        mb, me, cf, sr, il;
   logic [2:0]  hdr_tnf;
   logic [32:0] sum;

   assign mb      = in_byte[7];
   assign me      = in_byte[6];
   assign cf      = in_byte[5];
   assign sr      = in_byte[4];
   assign il      = in_byte[3];
   assign hdr_tnf = in_byte[2:0];

   always_comb begin
      phase_in    = phase_ff;
      hdr_in      = hdr_ff;
      tnf_in      = tnf_ff;
      type_cnt_in = type_cnt_ff;
      id_cnt_in   = id_cnt_ff;
      pay_cnt_in  = pay_cnt_ff;
      len_left_in = len_left_ff;
      in_chunk_in = in_chunk_ff;
      seen_in     = seen_ff;
      merged_in   = merged_ff;
      present_in  = present_ff;
      res         = '0;
      res.kind    = KIND_NONE;
      do_lk       = 1'b0;
      do_next     = 1'b0;
      do_end      = 1'b0;
      sum         = '0;

      case (phase_ff)
         PH_HEAD: begin
            res.have = 1'b1;
            if (!mb && !seen_ff && !in_chunk_ff && !cfg.single_mode) begin
               res.err = ERR_NO_MB;
            end else if (mb && (seen_ff || in_chunk_ff) && !cfg.single_mode) begin
               res.err = ERR_LATE_MB;
            end else if (in_chunk_ff && il) begin
               res.err = ERR_IL_IN_CHUNK;
            end else if (cf && me) begin
               res.err = ERR_CF_WITH_ME;
            end else if (in_chunk_ff && hdr_tnf != TNF_CONT_CHUNK) begin
               res.err = ERR_CHUNK_TNF;
            end else if (!in_chunk_ff && hdr_tnf == TNF_CONT_CHUNK) begin
               res.err = ERR_UNCHANGED_TNF;
            end else begin
               res.have    = 1'b0;
               hdr_in      = {me, cf, sr, il};
               if (!in_chunk_ff) begin
                  tnf_in = hdr_tnf;
               end
               type_cnt_in = '0;
               id_cnt_in   = '0;
               pay_cnt_in  = '0;
               phase_in    = PH_TYPELEN;
            end
            if (res.have) begin
               phase_in = PH_SKIP;
            end
         end
         PH_TYPELEN: begin
            type_cnt_in = in_byte;
            phase_in    = PH_PAYLEN;
            len_left_in = hdr_ff[HB_SR] ? 2'd0 : LEN_BYTES_AFTER_FIRST;
         end
         PH_PAYLEN: begin
            pay_cnt_in = {pay_cnt_ff[23:0], in_byte};
            if (len_left_ff != 2'd0) begin
               len_left_in = len_left_ff - 2'd1;
            end else if (hdr_ff[HB_IL]) begin
               phase_in = PH_IDLEN;
            end else begin
               id_cnt_in = '0;
               do_lk     = 1'b1;
            end
         end
         PH_IDLEN: begin
            id_cnt_in = in_byte;
            do_lk     = 1'b1;
         end
         PH_TYPE: begin
            res.have    = 1'b1;
            res.kind    = KIND_TYPE;
            res.data    = in_byte;
            type_cnt_in = type_cnt_ff - 8'd1;
            do_next     = (type_cnt_in == 8'd0);
         end
         PH_ID: begin
            res.have  = 1'b1;
            res.kind  = KIND_ID;
            res.data  = in_byte;
            id_cnt_in = id_cnt_ff - 8'd1;
            do_next   = (id_cnt_in == 8'd0);
         end
         PH_PAYLOAD: begin
            res.have   = 1'b1;
            res.kind   = KIND_PAYLOAD;
            res.data   = in_byte;
            pay_cnt_in = pay_cnt_ff - 32'd1;
            do_end     = (pay_cnt_in == 32'd0);
         end
         default: ;
      endcase

      // lengths complete: chunk and limit checks
      if (do_lk) begin
         sum = (in_chunk_ff ? {1'b0, merged_ff} : 33'd0) + {1'b0, pay_cnt_in};
         if (in_chunk_ff && type_cnt_in != 8'd0) begin
            res.err = ERR_CHUNK_TYPE;
         end else if (hdr_ff[HB_CF] && !in_chunk_ff && type_cnt_in == 8'd0 &&
                      tnf_in != TNF_OPAQUE) begin
            res.err = ERR_NO_TYPE;
         end else if (pay_cnt_in > cfg.max_payload) begin
            res.err = ERR_PAYLOAD_LONG;
         end else if ((in_chunk_ff || hdr_ff[HB_CF]) && sum > {1'b0, cfg.max_payload}) begin
            res.err = ERR_MERGED_LONG;
         end else begin
            merged_in = sum[31:0];
            if (!in_chunk_ff) begin
               present_in          = '0;
               present_in[PF_TYPE] = (type_cnt_in != 8'd0);
               present_in[PF_ID]   = (id_cnt_in != 8'd0);
            end
            if (pay_cnt_in != 32'd0) begin
               present_in[PF_PAYLOAD] = 1'b1;
            end
            do_next = 1'b1;
         end
         if (res.err != ERR_NONE) begin
            res.have = 1'b1;
            phase_in = PH_SKIP;
         end
      end

      if (do_next) begin
         if (type_cnt_in != 8'd0) begin
            phase_in = PH_TYPE;
         end else if (id_cnt_in != 8'd0) begin
            phase_in = PH_ID;
         end else if (pay_cnt_in != 32'd0) begin
            phase_in = PH_PAYLOAD;
         end else begin
            do_end = 1'b1;
         end
      end

      if (do_end) begin
         if (hdr_ff[HB_CF]) begin
            in_chunk_in = 1'b1;
            phase_in    = PH_HEAD;
         end else begin
            res.have    = 1'b1;
            res.done    = 1'b1;
            res.ok      = tnf_pass(tnf_in, present_in);
            seen_in     = 1'b1;
            in_chunk_in = 1'b0;
            if (hdr_ff[HB_ME] || cfg.single_mode) begin
               res.msg  = 1'b1;
               phase_in = PH_DONE;
            end else begin
               phase_in = PH_HEAD;
            end
         end
      end

      if (frame_last && phase_in != PH_DONE && phase_in != PH_SKIP) begin
         res.have = 1'b1;
         res.err  = ERR_TRUNCATED;
      end

      res.tnf = tnf_in;

      // end of frame: back to the reset state
      if (frame_last) begin
         phase_in    = PH_HEAD;
         hdr_in      = '0;
         tnf_in      = '0;
         type_cnt_in = '0;
         id_cnt_in   = '0;
         pay_cnt_in  = '0;
         len_left_in = '0;
         in_chunk_in = 1'b0;
         seen_in     = 1'b0;
         merged_in   = '0;
         present_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HEAD;
         hdr_ff      <= '0;
         tnf_ff      <= '0;
         type_cnt_ff <= '0;
         id_cnt_ff   <= '0;
         pay_cnt_ff  <= '0;
         len_left_ff <= '0;
         in_chunk_ff <= 1'b0;
         seen_ff     <= 1'b0;
         merged_ff   <= '0;
         present_ff  <= '0;
      end else if (step) begin
         phase_ff    <= phase_in;
         hdr_ff      <= hdr_in;
         tnf_ff      <= tnf_in;
         type_cnt_ff <= type_cnt_in;
         id_cnt_ff   <= id_cnt_in;
         pay_cnt_ff  <= pay_cnt_in;
         len_left_ff <= len_left_in;
         in_chunk_ff <= in_chunk_in;
         seen_ff     <= seen_in;
         merged_ff   <= merged_in;
         present_ff  <= present_in;
      end
   end

endmodule

// ===== rtl/ndef_record_deframer_unit.sv =====
// ndef record deframer: one request byte per cycle, at most one response per request.
// the request waits in the input register until the response register is free or being
// taken; then the parser step writes its result into the response register.
// throughput: one request per cycle while responses are taken; the only stall is a
// held response register. synchronous active-high reset clears all control state
// and sets single_record_mode to 0 and max_payload_len to 1048576.
`include "ndef_record_deframer_unit_defines.svh"
module ndef_record_deframer_unit
   import ndr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   input  logic        req_tlast,   // frame_last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] out_byte, [10:8] record_tnf, [11] record_ok, [12] message_done,
   // [16:13] error_code, [23:17] zero
   output logic [23:0] rsp_tdata,
   output logic [1:0]  rsp_tuser,   // kind
   output logic        rsp_tlast,   // record_done
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   ndr_cfg_type    cfg;
   ndr_result_type res;

   logic       s1_valid_ff, s1_valid_in;
   logic [7:0] s1_byte_ff;
   logic       s1_last_ff;
   logic       s1_adv;
   logic       rsp_valid_ff, rsp_valid_in;
   ndr_result_type rsp_ff;

   ndr_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   ndr_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .step       (s1_adv),
      .in_byte    (s1_byte_ff),
      .frame_last (s1_last_ff),
      .cfg        (cfg),
      .res        (res)
   );

   assign s1_adv     = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_adv;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_tready) begin
         s1_valid_in = req_tvalid;
      end
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      if (s1_adv) begin
         rsp_valid_in = res.have;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         s1_byte_ff <= req_tdata;
         s1_last_ff <= req_tlast;
      end
      if (s1_adv && res.have) begin
         rsp_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.kind;
   assign rsp_tlast  = rsp_ff.done;
   assign rsp_tdata  = {7'd0, rsp_ff.err, rsp_ff.msg, rsp_ff.ok, rsp_ff.tnf, rsp_ff.data};

   `NDR_ASSERT_NOW(a_err_no_data, clock, reset,
      rsp_tvalid && rsp_ff.err != ERR_NONE && rsp_ff.err != ERR_TRUNCATED,
      rsp_tuser == KIND_NONE && !rsp_tlast)
   `NDR_ASSERT_NOW(a_ok_with_done, clock, reset,
      rsp_tvalid && !rsp_tlast, !rsp_ff.ok && !rsp_ff.msg)
   `NDR_ASSERT_NOW(a_stall_blocks, clock, reset,
      s1_valid_ff && rsp_tvalid && !rsp_tready, !req_tready)
   `NDR_ASSERT_NEXT(a_nodata_zero, clock, reset,
      s1_adv && res.have && res.kind == KIND_NONE, rsp_tdata[7:0] == 8'd0)

endmodule
